### rtl/srr_pkg.sv
// shared types and constants for the selective repeat receiver
package srr_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int WIN_W = 5;
  localparam int LIM_W = 7;
  localparam int DATA_W = 160;
  localparam logic [7:0] SUM_OK = 8'hFF;

  localparam logic [0:0] CFG_WINDOW = 1'b0;
  localparam logic [0:0] CFG_LIMIT = 1'b1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [31:0] check_word;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_high;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_low;
    logic [63:0] data_mid;
    logic [31:0] data_high;
    logic [6:0]  next_expected_out;
    logic [7:0]  ack_checksum;
    logic        last;
  } out_word_t;

  // classified packet passed from front to back
  typedef struct packed {
    logic [31:0]       seq;
    logic [7:0]        paysum;
    logic [DATA_W-1:0] data;
  } pkt_t;

  function automatic logic [7:0] byte_sum(input logic [255:0] v, input int n);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < n) s = s + v[8*i +: 8];
    end
    return s;
  endfunction

endpackage

### rtl/srr_ram.sv
// generic single write, single read ram with registered read
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/srr_front.sv
// front: byte sum check, drops bad packets, queues good ones
module srr_front import srr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output pkt_t     q_pkt
);
  // two entry queue
  pkt_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic [7:0] hsum, psum;
  logic       good, push, pop;

  always_comb begin
    psum = byte_sum({96'd0, in_data.payload_high, in_data.payload_mid,
                     in_data.payload_low}, 20);
    hsum = byte_sum({160'd0, in_data.seq_number, in_data.ack_number,
                     in_data.check_word}, 12);
  end
  assign good = (8'(hsum + psum) == SUM_OK);
  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready && good;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_pkt = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
    if (push) q_r[wr_r] <= '{seq: in_data.seq_number, paysum: psum,
        data: {in_data.payload_high, in_data.payload_mid, in_data.payload_low}};
  end
endmodule

### rtl/srr_back.sv
// back: window check, slot buffering, in-order drain and ack
module srr_back import srr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  pkt_t             q_pkt,
  input  logic [WIN_W-1:0] win_reg,
  input  logic [LIM_W-1:0] lim_reg,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_CLASS = 5'b00100,
    S_DRAIN = 5'b01000,
    S_ACK   = 5'b10000
  } state_t;

  state_t                st_r, st_nxt;
  logic [MAX_WINDOW-1:0] full_r;
  logic [LIM_W-1:0]      exp_seq_r;
  logic [LIM_W-1:0]      seq_red_r;  // exp_seq_r reduced mod lim
  logic [SLOT_W-1:0]     exp_slot_r;
  pkt_t                  pkt_r;
  logic [31:0]           val_r;      // wrapped seq + lim - exp, shifted out msb first
  logic [LIM_W-1:0]      part_r;
  logic [LIM_W-1:0]      rem_r;
  logic [5:0]            step_r;
  logic                  first_r;    // first delivery is the word just stored
  out_word_t             ob_r;

  logic [WIN_W-1:0]      win;
  logic [LIM_W-1:0]      lim;
  logic [SLOT_W-1:0]     idx, slot_inc;
  logic [5:0]            idx_sum;
  logic [DATA_W-1:0]     rd_data, drain_data;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_ra;
  logic                  out_free, out_load;
  logic [LIM_W-1:0]      seq_inc;
  logic [LIM_W:0]        part_sh;
  logic [12:0]           lim_sh;
  logic [7:0]            nsum, ack_ck;

  assign win = (win_reg == '0) ? 5'd1 :
               (win_reg > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : win_reg;
  assign lim = (lim_reg < 7'd2) ? 7'd2 : lim_reg;
  assign idx_sum = 6'(exp_slot_r) + 6'(rem_r);
  assign idx = (idx_sum >= 6'(win)) ? SLOT_W'(idx_sum - 6'(win)) : SLOT_W'(idx_sum);
  assign slot_inc = (5'(exp_slot_r) + 5'd1 == win) ? '0 : exp_slot_r + SLOT_W'(1);
  assign seq_inc = (seq_red_r + 7'd1 == lim) ? '0 : seq_red_r + 7'd1;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((st_r == S_DRAIN) || (st_r == S_ACK));
  assign q_ready = (st_r == S_IDLE);
  assign ram_we = (st_r == S_CLASS) && (rem_r < 7'(win)) && !full_r[idx];
  assign ram_ra = ram_we ? idx : (out_free ? slot_inc : exp_slot_r);
  assign drain_data = first_r ? pkt_r.data : rd_data;

  srr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WINDOW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(idx), .wdata(pkt_r.data),
    .raddr(ram_ra), .rdata(rd_data)
  );

  assign nsum = 8'(exp_seq_r) + pkt_r.paysum;
  assign ack_ck = ~nsum;

  // restoring reduction, one bit a cycle
  assign part_sh = {part_r, val_r[31]};
  assign lim_sh = 13'(lim) << (3'd6 - step_r[2:0]);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = S_MOD;
      S_MOD:   if (step_r == 6'd32) st_nxt = S_CLASS;
      S_CLASS: st_nxt = ram_we && (rem_r == '0) ? S_DRAIN : S_ACK;
      S_DRAIN: if (out_free && !(full_r[slot_inc] && slot_inc != exp_slot_r))
                 st_nxt = S_ACK;
      S_ACK:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      full_r <= '0;
      exp_seq_r <= '0;
      exp_slot_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            pkt_r <= q_pkt;
            val_r <= q_pkt.seq + 32'(lim) - 32'(exp_seq_r);
            seq_red_r <= exp_seq_r;
            part_r <= '0;
            step_r <= '0;
          end
        end
        S_MOD: begin
          // slot index brought below the window by repeated subtraction
          if ({1'b0, exp_slot_r} >= win)
            exp_slot_r <= SLOT_W'({1'b0, exp_slot_r} - win);
          // expected seq brought below lim, lim*64 down to lim
          if (step_r < 6'd7 && 13'(seq_red_r) >= lim_sh)
            seq_red_r <= LIM_W'(13'(seq_red_r) - lim_sh);
          if (step_r < 6'd32) begin
            val_r <= {val_r[30:0], 1'b0};
            part_r <= (part_sh >= {1'b0, lim}) ? LIM_W'(part_sh - {1'b0, lim}) :
                      part_sh[LIM_W-1:0];
            step_r <= step_r + 6'd1;
          end else begin
            rem_r <= part_r;
            step_r <= '0;
          end
        end
        S_CLASS: begin
          if (ram_we) full_r[idx] <= 1'b1;
          first_r <= 1'b1;
        end
        S_DRAIN: begin
          if (out_free) begin
            ob_r <= '{kind: KIND_DELIVER, data_low: drain_data[63:0],
                      data_mid: drain_data[127:64], data_high: drain_data[159:128],
                      next_expected_out: '0, ack_checksum: '0, last: 1'b0};
            full_r[exp_slot_r] <= 1'b0;
            exp_slot_r <= slot_inc;
            exp_seq_r <= seq_inc;
            seq_red_r <= seq_inc;
            first_r <= 1'b0;
          end
        end
        S_ACK: begin
          if (out_free) begin
            ob_r <= '{kind: KIND_ACK, data_low: pkt_r.data[63:0],
                      data_mid: pkt_r.data[127:64], data_high: pkt_r.data[159:128],
                      next_expected_out: exp_seq_r, ack_checksum: ack_ck, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end
  assign out_data = ob_r;
endmodule

### rtl/selective_repeat_receiver_unit.sv
// top level: selective repeat receiver with config registers
// delivered results leave one a cycle while out_ready is high; the back end
// takes no new packet until the current one is acked, and its bit-serial
// sequence offset reduction runs before each packet is classified
// reset: rst_n synchronous active low; slots empty, expected numbers zero,
// window 8 and sequence limit 16
module selective_repeat_receiver_unit import srr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);
  logic [WIN_W-1:0] win_r;
  logic [LIM_W-1:0] lim_r;
  logic q_valid, q_ready;
  pkt_t q_pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 5'd8;
      lim_r <= 7'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: win_r <= cfg_wdata[WIN_W-1:0];
        CFG_LIMIT:  lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  srr_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
                     .q_valid, .q_ready, .q_pkt);
  srr_back u_back (.clk, .rst_n, .q_valid, .q_ready, .q_pkt,
                   .win_reg(win_r), .lim_reg(lim_r), .out_valid, .out_ready,
                   .out_data);

  a_last_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == out_data.kind)) else $error("last mismatch");
  a_deliv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> out_data.ack_checksum == '0)
    else $error("delivery checksum");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
endmodule
